FILE: hdl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

FILE: hdl/qinv_pkg.sv
// types and constants of the quaternion inverse and normalise block
package qinv_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int N_LANES    = 4;
   localparam int COMP_W     = 32;
   localparam int SQ_W       = 2 * COMP_W;
   localparam int SUM_W      = SQ_W + 1;
   localparam int ROOT_W     = (SUM_W + 1) / 2;
   localparam int REM_W      = SUM_W + 1;
   localparam int QUO_W      = 32;
   localparam int DIV_W      = COMP_W + 2 * FRAC_BITS;
   localparam int SQRT_STEPS = ROOT_W;
   localparam int DIV_STEPS  = QUO_W;
   localparam int THR_W      = 16;
   localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

   localparam logic [COMP_W-1:0] COMP_MAX = {1'b0, {(COMP_W-1){1'b1}}};
   localparam logic [COMP_W-1:0] COMP_MIN = {1'b1, {(COMP_W-1){1'b0}}};

   typedef enum logic [1:0] {
      KIND_CONJ = 2'd0,
      KIND_INV  = 2'd1,
      KIND_NORM = 2'd2,
      KIND_PASS = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type                       kind;
      logic [N_LANES-1:0]             neg;
      logic [N_LANES-1:0][COMP_W-1:0] mag;
      logic [SUM_W-1:0]               sum;
   } side_type;

   typedef struct packed {
      logic [N_LANES-1:0][COMP_W-1:0] comp;
      logic [COMP_W-1:0]              norm;
      logic                           zero;
      logic                           ovf;
   } res_type;

endpackage

FILE: hdl/qinv_if.sv
// request and response channel interfaces
interface qinv_req_if;
   import qinv_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [1:0]               kind;
   logic signed [COMP_W-1:0] w_in;
   logic signed [COMP_W-1:0] x_in;
   logic signed [COMP_W-1:0] y_in;
   logic signed [COMP_W-1:0] z_in;
   modport source (output valid, kind, w_in, x_in, y_in, z_in, input ready);
   modport sink (input valid, kind, w_in, x_in, y_in, z_in, output ready);
endinterface

interface qinv_rsp_if;
   import qinv_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [COMP_W-1:0] w_out;
   logic signed [COMP_W-1:0] x_out;
   logic signed [COMP_W-1:0] y_out;
   logic signed [COMP_W-1:0] z_out;
   logic [COMP_W-1:0]        norm_out;
   logic                     zero_flag;
   logic                     overflow_flag;
   modport source (output valid, w_out, x_out, y_out, z_out, norm_out, zero_flag,
                   overflow_flag, input ready);
   modport sink (input valid, w_out, x_out, y_out, z_out, norm_out, zero_flag,
                 overflow_flag, output ready);
endinterface

FILE: hdl/qinv_sqrt.sv
// pipelined integer square root, one root bit per stage
module qinv_sqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  qinv_pkg::side_type           side_in,
   output logic                         out_valid,
   output logic [qinv_pkg::ROOT_W-1:0]  root,
   output qinv_pkg::side_type           side_out
);
   import qinv_pkg::*;

   logic                    valid_ff [SQRT_STEPS];
   logic [REM_W-1:0]        n_ff     [SQRT_STEPS];
   logic [REM_W-1:0]        res_ff   [SQRT_STEPS];
   side_type                side_ff  [SQRT_STEPS];
   logic [REM_W-1:0]        n_in     [SQRT_STEPS];
   logic [REM_W-1:0]        res_in   [SQRT_STEPS];

   always_comb begin
      logic [REM_W-1:0] n_prev;
      logic [REM_W-1:0] res_prev;
      logic [REM_W-1:0] bit_k;
      logic [REM_W-1:0] trial;
      for (int k = 0; k < SQRT_STEPS; k++) begin
         if (k == 0) begin
            n_prev   = REM_W'(side_in.sum);
            res_prev = '0;
         end else begin
            n_prev   = n_ff[k-1];
            res_prev = res_ff[k-1];
         end
         bit_k = REM_W'(1) << (2 * (SQRT_STEPS - 1 - k));
         trial = res_prev + bit_k;
         if (n_prev >= trial) begin
            n_in[k]   = n_prev - trial;
            res_in[k] = (res_prev >> 1) + bit_k;
         end else begin
            n_in[k]   = n_prev;
            res_in[k] = res_prev >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SQRT_STEPS; k++) valid_ff[k] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k < SQRT_STEPS; k++) valid_ff[k] <= valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int k = 1; k < SQRT_STEPS; k++) side_ff[k] <= side_ff[k-1];
         for (int k = 0; k < SQRT_STEPS; k++) begin
            n_ff[k]   <= n_in[k];
            res_ff[k] <= res_in[k];
         end
      end
   end

   assign out_valid = valid_ff[SQRT_STEPS-1];
   assign root      = res_ff[SQRT_STEPS-1][ROOT_W-1:0];
   assign side_out  = side_ff[SQRT_STEPS-1];

endmodule

FILE: hdl/qinv_div_lane.sv
// one divider lane, restoring division with one quotient bit per stage
module qinv_div_lane (
   input  logic                        clock,
   input  logic                        en,
   input  logic [qinv_pkg::SUM_W-1:0]  d,
   input  logic [qinv_pkg::REM_W-1:0]  r0,
   input  logic [qinv_pkg::QUO_W-1:0]  dl,
   input  logic                        hi,
   input  logic                        neg,
   output logic [qinv_pkg::QUO_W-1:0]  q,
   output logic                        hi_out,
   output logic                        neg_out
);
   import qinv_pkg::*;

   logic [REM_W-1:0] r_ff   [DIV_STEPS];
   logic [QUO_W-1:0] q_ff   [DIV_STEPS];
   logic [QUO_W-1:0] dl_ff  [DIV_STEPS];
   logic [SUM_W-1:0] d_ff   [DIV_STEPS];
   logic             hi_ff  [DIV_STEPS];
   logic             neg_ff [DIV_STEPS];
   logic [REM_W-1:0] r_in   [DIV_STEPS];
   logic [QUO_W-1:0] q_in   [DIV_STEPS];

   always_comb begin
      logic [REM_W-1:0] r_prev;
      logic [QUO_W-1:0] q_prev;
      logic [QUO_W-1:0] dl_prev;
      logic [SUM_W-1:0] d_prev;
      logic [REM_W-1:0] r_sh;
      for (int k = 0; k < DIV_STEPS; k++) begin
         if (k == 0) begin
            r_prev  = r0;
            q_prev  = '0;
            dl_prev = dl;
            d_prev  = d;
         end else begin
            r_prev  = r_ff[k-1];
            q_prev  = q_ff[k-1];
            dl_prev = dl_ff[k-1];
            d_prev  = d_ff[k-1];
         end
         // partial remainder stays below the divisor, so the top bit is free
         r_sh = {r_prev[REM_W-2:0], dl_prev[QUO_W-1]};
         if (r_sh >= REM_W'(d_prev)) begin
            r_in[k] = r_sh - REM_W'(d_prev);
            q_in[k] = {q_prev[QUO_W-2:0], 1'b1};
         end else begin
            r_in[k] = r_sh;
            q_in[k] = {q_prev[QUO_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dl_ff[0]  <= dl << 1;
         d_ff[0]   <= d;
         hi_ff[0]  <= hi;
         neg_ff[0] <= neg;
         for (int k = 1; k < DIV_STEPS; k++) begin
            dl_ff[k]  <= dl_ff[k-1] << 1;
            d_ff[k]   <= d_ff[k-1];
            hi_ff[k]  <= hi_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
         end
         for (int k = 0; k < DIV_STEPS; k++) begin
            r_ff[k] <= r_in[k];
            q_ff[k] <= q_in[k];
         end
      end
   end

   assign q       = q_ff[DIV_STEPS-1];
   assign hi_out  = hi_ff[DIV_STEPS-1];
   assign neg_out = neg_ff[DIV_STEPS-1];

endmodule

FILE: hdl/quaternion_inverse_normalize.sv
// top level: quaternion conjugate, inverse, normalise and pass-through pipeline
// Takes one quaternion transaction per clock while the skid register is empty and
// returns one result per transaction, in order. There are 71 register stages,
// and the input stage is loaded at the accepting edge: one input stage, one
// squaring stage (32x32 multiply per component), two adder stages, 33 square
// root stages (one root bit each), one divisor set-up stage, 32 stages in each
// of the four divider lanes (one quotient bit each) and the output register. A
// skid register behind the output keeps req ready registered; throughput is one
// transaction per clock while the skid register is empty.
`include "assert_macros.svh"

module quaternion_inverse_normalize (
   input  logic                        clock,
   input  logic                        reset,
   qinv_req_if.sink                    req_if,
   qinv_rsp_if.source                  rsp_if,
   input  logic                        csr_we,
   input  logic [qinv_pkg::THR_W-1:0]  csr_wdata
);
   import qinv_pkg::*;

   logic [THR_W-1:0] thr_ff;
   logic             en;
   logic             out_take;
   logic             rsp_valid_ff;
   logic             skid_valid_ff;
   res_type          rsp_data_ff;
   res_type          skid_data_ff;

   // input stage
   logic [N_LANES-1:0][COMP_W-1:0] comp_in;
   side_type                       a_side_in;
   logic                           a_valid_ff;
   side_type                       a_side_ff;
   // squares
   logic                           b_valid_ff;
   side_type                       b_side_ff;
   logic [N_LANES-1:0][SQ_W-1:0]   b_sq_ff;
   // pair sums
   logic                           c_valid_ff;
   side_type                       c_side_ff;
   logic [1:0][SUM_W-1:0]          c_pair_ff;
   // full sum
   logic [SUM_W:0]                 d_sum_in;
   side_type                       d_side_in;
   logic                           d_valid_ff;
   side_type                       d_side_ff;
   // square root output
   logic                           s_valid;
   logic [ROOT_W-1:0]              s_root;
   side_type                       s_side;
   // divisor set-up
   logic                           z_zero_in;
   logic [SUM_W-1:0]               z_d_in;
   logic [N_LANES-1:0][DIV_W-1:0]  dvd_in;
   logic [N_LANES-1:0]             flip_in;
   logic [N_LANES-1:0][REM_W-1:0]  z_r0_in;
   logic [N_LANES-1:0][QUO_W-1:0]  z_dl_in;
   logic [N_LANES-1:0]             z_hi_in;
   logic [N_LANES-1:0]             z_neg_in;
   logic                           z_valid_ff;
   logic                           z_zero_ff;
   logic [ROOT_W-1:0]              z_norm_ff;
   logic [SUM_W-1:0]               z_d_ff;
   logic [N_LANES-1:0][REM_W-1:0]  z_r0_ff;
   logic [N_LANES-1:0][QUO_W-1:0]  z_dl_ff;
   logic [N_LANES-1:0]             z_hi_ff;
   logic [N_LANES-1:0]             z_neg_ff;
   // lane outputs and the matching delay line
   logic [N_LANES-1:0][QUO_W-1:0]  l_q;
   logic [N_LANES-1:0]             l_hi;
   logic [N_LANES-1:0]             l_neg;
   logic                           p_valid_ff [DIV_STEPS];
   logic                           p_zero_ff  [DIV_STEPS];
   logic [ROOT_W-1:0]              p_norm_ff  [DIV_STEPS];
   res_type                        res_in;

   assign en           = !skid_valid_ff;
   assign req_if.ready = en;
   assign out_take     = rsp_valid_ff && rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_we) begin
         thr_ff <= csr_wdata;
      end
   end

   assign comp_in = {req_if.z_in, req_if.y_in, req_if.x_in, req_if.w_in};

   always_comb begin
      a_side_in      = '0;
      a_side_in.kind = kind_type'(req_if.kind);
      for (int i = 0; i < N_LANES; i++) begin
         a_side_in.neg[i] = comp_in[i][COMP_W-1];
         a_side_in.mag[i] = comp_in[i][COMP_W-1] ? (-comp_in[i]) : comp_in[i];
      end
   end

   assign d_sum_in = {1'b0, c_pair_ff[0]} + {1'b0, c_pair_ff[1]};

   always_comb begin
      d_side_in     = c_side_ff;
      d_side_in.sum = d_sum_in[SUM_W-1:0];
   end

   // divisor and dividend per operation
   always_comb begin
      z_zero_in = 1'b0;
      z_d_in    = SUM_W'(1);
      unique case (s_side.kind)
         KIND_INV: begin
            z_d_in    = s_side.sum;
            z_zero_in = REM_W'(s_side.sum) <= (REM_W'(thr_ff) << FRAC_BITS);
         end
         KIND_NORM: begin
            z_d_in    = SUM_W'(s_root);
            z_zero_in = s_root <= ROOT_W'(thr_ff);
         end
         KIND_CONJ, KIND_PASS: begin
            z_d_in    = SUM_W'(1);
            z_zero_in = 1'b0;
         end
         default: begin
            z_d_in    = SUM_W'(1);
            z_zero_in = 1'b0;
         end
      endcase
      for (int i = 0; i < N_LANES; i++) begin
         unique case (s_side.kind)
            KIND_INV: begin
               dvd_in[i]  = DIV_W'(s_side.mag[i]) << (2 * FRAC_BITS);
               flip_in[i] = (i != 0);
            end
            KIND_NORM: begin
               dvd_in[i]  = DIV_W'(s_side.mag[i]) << FRAC_BITS;
               flip_in[i] = 1'b0;
            end
            KIND_CONJ: begin
               dvd_in[i]  = DIV_W'(s_side.mag[i]);
               flip_in[i] = (i != 0);
            end
            default: begin
               dvd_in[i]  = DIV_W'(s_side.mag[i]);
               flip_in[i] = 1'b0;
            end
         endcase
         z_r0_in[i]  = REM_W'(dvd_in[i] >> QUO_W);
         // quotient would reach 2^32: saturates whatever the low bits
         z_hi_in[i]  = z_r0_in[i] >= REM_W'(z_d_in);
         z_dl_in[i]  = dvd_in[i][QUO_W-1:0];
         z_neg_in[i] = s_side.neg[i] ^ flip_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         z_valid_ff <= 1'b0;
         for (int k = 0; k < DIV_STEPS; k++) p_valid_ff[k] <= 1'b0;
      end else if (en) begin
         a_valid_ff    <= req_if.valid;
         b_valid_ff    <= a_valid_ff;
         c_valid_ff    <= b_valid_ff;
         d_valid_ff    <= c_valid_ff;
         z_valid_ff    <= s_valid;
         p_valid_ff[0] <= z_valid_ff;
         for (int k = 1; k < DIV_STEPS; k++) p_valid_ff[k] <= p_valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_side_ff <= a_side_in;
         b_side_ff <= a_side_ff;
         for (int i = 0; i < N_LANES; i++) begin
            b_sq_ff[i] <= SQ_W'(a_side_ff.mag[i]) * SQ_W'(a_side_ff.mag[i]);
         end
         c_side_ff    <= b_side_ff;
         c_pair_ff[0] <= {1'b0, b_sq_ff[0]} + {1'b0, b_sq_ff[1]};
         c_pair_ff[1] <= {1'b0, b_sq_ff[2]} + {1'b0, b_sq_ff[3]};
         d_side_ff    <= d_side_in;
         z_zero_ff <= z_zero_in;
         z_norm_ff <= s_root;
         z_d_ff    <= z_d_in;
         z_r0_ff   <= z_r0_in;
         z_dl_ff   <= z_dl_in;
         z_hi_ff   <= z_hi_in;
         z_neg_ff  <= z_neg_in;
         p_zero_ff[0] <= z_zero_ff;
         p_norm_ff[0] <= z_norm_ff;
         for (int k = 1; k < DIV_STEPS; k++) begin
            p_zero_ff[k] <= p_zero_ff[k-1];
            p_norm_ff[k] <= p_norm_ff[k-1];
         end
      end
   end

   qinv_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d_valid_ff),
      .side_in   (d_side_ff),
      .out_valid (s_valid),
      .root      (s_root),
      .side_out  (s_side)
   );

   for (genvar i = 0; i < N_LANES; i++) begin : g_lane
      qinv_div_lane u_lane (
         .clock   (clock),
         .en      (en),
         .d       (z_d_ff),
         .r0      (z_r0_ff[i]),
         .dl      (z_dl_ff[i]),
         .hi      (z_hi_ff[i]),
         .neg     (z_neg_ff[i]),
         .q       (l_q[i]),
         .hi_out  (l_hi[i]),
         .neg_out (l_neg[i])
      );
   end

   // merge: sign, saturation and the zero override
   always_comb begin
      res_in     = '0;
      res_in.ovf = 1'b0;
      for (int i = 0; i < N_LANES; i++) begin
         if (l_neg[i]) begin
            if (l_hi[i] || (l_q[i] > COMP_MIN)) begin
               res_in.comp[i] = COMP_MIN;
               res_in.ovf     = 1'b1;
            end else begin
               res_in.comp[i] = -l_q[i];
            end
         end else begin
            if (l_hi[i] || l_q[i][QUO_W-1]) begin
               res_in.comp[i] = COMP_MAX;
               res_in.ovf     = 1'b1;
            end else begin
               res_in.comp[i] = l_q[i];
            end
         end
      end
      if (p_zero_ff[DIV_STEPS-1]) begin
         res_in.comp = '0;
         res_in.ovf  = 1'b0;
      end
      res_in.zero = p_zero_ff[DIV_STEPS-1];
      res_in.norm = p_norm_ff[DIV_STEPS-1][ROOT_W-1] ? '1 :
                    p_norm_ff[DIV_STEPS-1][COMP_W-1:0];
   end

   // output register with skid behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_take) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (!rsp_valid_ff || out_take) begin
         rsp_valid_ff <= p_valid_ff[DIV_STEPS-1];
      end else if (p_valid_ff[DIV_STEPS-1]) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_take) begin
            rsp_data_ff <= skid_data_ff;
         end
      end else if (!rsp_valid_ff || out_take) begin
         rsp_data_ff <= res_in;
      end else begin
         skid_data_ff <= res_in;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.w_out         = rsp_data_ff.comp[0];
   assign rsp_if.x_out         = rsp_data_ff.comp[1];
   assign rsp_if.y_out         = rsp_data_ff.comp[2];
   assign rsp_if.z_out         = rsp_data_ff.comp[3];
   assign rsp_if.norm_out      = rsp_data_ff.norm;
   assign rsp_if.zero_flag     = rsp_data_ff.zero;
   assign rsp_if.overflow_flag = rsp_data_ff.ovf;

   `ASSERT_SAME(a_skid_behind_out, clock, reset, skid_valid_ff, rsp_valid_ff)
   `ASSERT_NEXT(a_skid_holds, clock, reset, skid_valid_ff && !rsp_if.ready, skid_valid_ff)
   `ASSERT_SAME(a_zero_clears, clock, reset, rsp_valid_ff && rsp_data_ff.zero, rsp_data_ff.comp == '0 && !rsp_data_ff.ovf)

endmodule
